// ===== rtl/tspf_pkg.sv =====
// Package for the task-space PID force regulator.
// Holds the sequencer states, opcodes, register indexes, a saturation helper and an absolute-value helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tspf_pkg;

  localparam int FracBitsDefault = 16;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [2:0] CFG_TGT_X   = 3'd0;
  localparam logic [2:0] CFG_TGT_Y   = 3'd1;
  localparam logic [2:0] CFG_TGT_Z   = 3'd2;
  localparam logic [2:0] CFG_GAIN_P  = 3'd3;
  localparam logic [2:0] CFG_GAIN_D  = 3'd4;
  localparam logic [2:0] CFG_GAIN_I  = 3'd5;
  localparam logic [2:0] CFG_LIMIT   = 3'd6;
  localparam logic [2:0] CFG_LIM_EN  = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ERR,
    ST_INT_MUL,
    ST_INT_ADD,
    ST_NP,
    ST_ND,
    ST_NI,
    ST_NU,
    ST_VP,
    ST_VI,
    ST_VSUM,
    ST_DIV,
    ST_VQ,
    ST_SQM,
    ST_SQA,
    ST_SQRT,
    ST_CMP,
    ST_CM,
    ST_CS,
    ST_CQ,
    ST_UM,
    ST_UA,
    ST_FM,
    ST_FA,
    ST_DONE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    logic [63:0] r;
    r = x[63] ? 64'(-x) : 64'(x);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/task_space_pid_force.sv =====
// Top level of the task-space PID force regulator.
// One shared 32x32 multiplier, a radix-2 divider and a square-root unit under a sequencer.
// Depends on tspf_pkg.
//
// Channel   Direction  Handshake          Content
// s_*       in         s_tvalid/s_tready  control item: opcode in tuser, operands in tdata
// m_*       out        m_tvalid/m_tready  force vector in tdata, clamp flag in tuser
// cfg_*     in         cfg_we             register write, no read-back
//
// Load and clear items are handled in the idle state. A saturating step runs the
// bit-serial divider once per axis, and once more per axis when the norm is clamped.
// Items enter only while the sequencer is idle. A finished result sits in the output
// register until taken; the sequencer waits in its last state while that register
// is still full. Reset is synchronous.
`timescale 1ns / 1ps
`default_nettype none
module task_space_pid_force #(
  parameter int FRAC_BITS = tspf_pkg::FracBitsDefault
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // matrix_entry, meas_pos_x/y/z, meas_vel_x/y/z, want_vel_x/y/z, step_time
  input  wire logic [335:0] s_tdata,
  // opcode
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // force_x, force_y, force_z
  output logic [95:0]       m_tdata,
  // speed_clamped
  output logic              m_tuser,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam logic [30:0] GainPReset = 31'(50 << FRAC_BITS);
  localparam logic [30:0] GainDReset = 31'(14 << FRAC_BITS);
  localparam logic [30:0] LimitReset = 31'(((3 << FRAC_BITS) + 5) / 10);

  tspf_pkg::state_t state, state_next;

  logic signed [31:0] target [3];
  logic [30:0]        gain_p, gain_d, gain_i, speed_limit;
  logic               limit_enable;

  logic signed [31:0] inertia [9];
  logic [3:0]         load_ptr;
  logic signed [31:0] integ [3];

  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [31:0] want [3];
  logic [15:0]        dt;

  logic signed [31:0] err [3];
  logic signed [31:0] vc [3];
  logic signed [31:0] u [3];
  logic signed [31:0] force_v [3];

  logic [1:0]         ax, row;
  logic [3:0]         mi;
  logic [5:0]         cnt;
  logic signed [63:0] acc, p;
  logic [63:0]        sq;
  logic               clamped, neg;

  logic [63:0]        dq;
  logic [31:0]        drem, ddiv;
  logic [63:0]        sx;
  logic [32:0]        srem;
  logic [31:0]        root;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [31:0] dv_n, dv_s;
  logic [32:0]        rem_sh;
  logic               div_ge;
  logic [34:0]        sq_sh, sq_trial;
  logic               sq_ge;
  logic signed [63:0] num;
  logic [30:0]        kd_div;
  logic signed [63:0] nsum;

  assign prod     = mul_a * mul_b;
  assign dv_n     = tspf_pkg::sat32(64'(vel[ax]) - 64'(want[ax]));
  assign dv_s     = tspf_pkg::sat32(64'(vel[ax]) - 64'(vc[ax]));
  assign rem_sh   = {drem, dq[63]};
  assign div_ge   = rem_sh >= {1'b0, ddiv};
  assign sq_sh    = {srem[32:0], sx[63:62]};
  assign sq_trial = {1'b0, root, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign num      = acc + p;
  assign kd_div   = (gain_d == 31'd0) ? 31'd1 : gain_d;
  assign nsum     = acc + (p >>> FRAC_BITS);

  always_comb begin
    state_next = state;
    unique case (state)
      tspf_pkg::ST_IDLE: begin
        if (s_tvalid && s_tuser == tspf_pkg::OP_STEP) state_next = tspf_pkg::ST_ERR;
      end
      tspf_pkg::ST_ERR:     state_next = tspf_pkg::ST_INT_MUL;
      tspf_pkg::ST_INT_MUL: state_next = tspf_pkg::ST_INT_ADD;
      tspf_pkg::ST_INT_ADD: begin
        if (ax != 2'd2) state_next = tspf_pkg::ST_INT_MUL;
        else if (limit_enable) state_next = tspf_pkg::ST_VP;
        else state_next = tspf_pkg::ST_NP;
      end
      tspf_pkg::ST_NP:   state_next = tspf_pkg::ST_ND;
      tspf_pkg::ST_ND:   state_next = tspf_pkg::ST_NI;
      tspf_pkg::ST_NI:   state_next = tspf_pkg::ST_NU;
      tspf_pkg::ST_NU:   state_next = (ax == 2'd2) ? tspf_pkg::ST_FM : tspf_pkg::ST_NP;
      tspf_pkg::ST_VP:   state_next = tspf_pkg::ST_VI;
      tspf_pkg::ST_VI:   state_next = tspf_pkg::ST_VSUM;
      tspf_pkg::ST_VSUM: state_next = tspf_pkg::ST_DIV;
      tspf_pkg::ST_DIV: begin
        if (cnt == 6'd63) state_next = clamped ? tspf_pkg::ST_CQ : tspf_pkg::ST_VQ;
      end
      tspf_pkg::ST_VQ:   state_next = (ax == 2'd2) ? tspf_pkg::ST_SQM : tspf_pkg::ST_VP;
      tspf_pkg::ST_SQM:  state_next = tspf_pkg::ST_SQA;
      tspf_pkg::ST_SQA:  state_next = (ax == 2'd2) ? tspf_pkg::ST_SQRT : tspf_pkg::ST_SQM;
      tspf_pkg::ST_SQRT: begin
        if (cnt == 6'd31) state_next = tspf_pkg::ST_CMP;
      end
      tspf_pkg::ST_CMP: begin
        state_next = (root > {1'b0, speed_limit}) ? tspf_pkg::ST_CM : tspf_pkg::ST_UM;
      end
      tspf_pkg::ST_CM:   state_next = tspf_pkg::ST_CS;
      tspf_pkg::ST_CS:   state_next = tspf_pkg::ST_DIV;
      tspf_pkg::ST_CQ:   state_next = (ax == 2'd2) ? tspf_pkg::ST_UM : tspf_pkg::ST_CM;
      tspf_pkg::ST_UM:   state_next = tspf_pkg::ST_UA;
      tspf_pkg::ST_UA:   state_next = (ax == 2'd2) ? tspf_pkg::ST_FM : tspf_pkg::ST_UM;
      tspf_pkg::ST_FM:   state_next = tspf_pkg::ST_FA;
      tspf_pkg::ST_FA:   state_next = (mi == 4'd8) ? tspf_pkg::ST_DONE : tspf_pkg::ST_FM;
      tspf_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = tspf_pkg::ST_IDLE;
      end
      default: state_next = tspf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == tspf_pkg::ST_IDLE);
    mul_a    = '0;
    mul_b    = '0;
    unique case (state) inside
      tspf_pkg::ST_INT_MUL: begin
        mul_a = err[ax];
        mul_b = {16'd0, dt};
      end
      tspf_pkg::ST_NP, tspf_pkg::ST_VP: begin
        mul_a = {1'b0, gain_p};
        mul_b = err[ax];
      end
      tspf_pkg::ST_ND: begin
        mul_a = {1'b0, gain_d};
        mul_b = dv_n;
      end
      tspf_pkg::ST_NI, tspf_pkg::ST_VI: begin
        mul_a = {1'b0, gain_i};
        mul_b = integ[ax];
      end
      tspf_pkg::ST_SQM: begin
        mul_a = vc[ax];
        mul_b = vc[ax];
      end
      tspf_pkg::ST_CM: begin
        mul_a = vc[ax];
        mul_b = {1'b0, speed_limit};
      end
      tspf_pkg::ST_UM: begin
        mul_a = {1'b0, gain_d};
        mul_b = dv_s;
      end
      tspf_pkg::ST_FM: begin
        mul_a = inertia[mi];
        mul_b = u[ax];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tspf_pkg::ST_IDLE;
      m_tvalid     <= 1'b0;
      load_ptr     <= '0;
      target[0]    <= '0;
      target[1]    <= '0;
      target[2]    <= '0;
      integ[0]     <= '0;
      integ[1]     <= '0;
      integ[2]     <= '0;
      gain_p       <= GainPReset;
      gain_d       <= GainDReset;
      gain_i       <= '0;
      speed_limit  <= LimitReset;
      limit_enable <= 1'b0;
      for (int i = 0; i < 9; i++) inertia[i] <= '0;
      ax           <= '0;
      row          <= '0;
      mi           <= '0;
      cnt          <= '0;
      clamped      <= 1'b0;
    end else begin
      state <= state_next;
      p     <= prod;

      if (state == tspf_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {force_v[2], force_v[1], force_v[0]};
        m_tuser  <= clamped;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          tspf_pkg::CFG_TGT_X:  target[0]    <= cfg_data;
          tspf_pkg::CFG_TGT_Y:  target[1]    <= cfg_data;
          tspf_pkg::CFG_TGT_Z:  target[2]    <= cfg_data;
          tspf_pkg::CFG_GAIN_P: gain_p       <= cfg_data[30:0];
          tspf_pkg::CFG_GAIN_D: gain_d       <= cfg_data[30:0];
          tspf_pkg::CFG_GAIN_I: gain_i       <= cfg_data[30:0];
          tspf_pkg::CFG_LIMIT:  speed_limit  <= cfg_data[30:0];
          tspf_pkg::CFG_LIM_EN: limit_enable <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (state)
        tspf_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            for (int c = 0; c < 3; c++) begin
              pos[c]  <= s_tdata[32 + 32*c +: 32];
              vel[c]  <= s_tdata[128 + 32*c +: 32];
              want[c] <= s_tdata[224 + 32*c +: 32];
            end
            dt <= s_tdata[335:320];
            unique case (s_tuser)
              tspf_pkg::OP_LOAD: begin
                inertia[load_ptr] <= s_tdata[31:0];
                load_ptr <= (load_ptr == 4'd8) ? 4'd0 : load_ptr + 4'd1;
              end
              tspf_pkg::OP_CLEAR: begin
                integ[0] <= '0;
                integ[1] <= '0;
                integ[2] <= '0;
              end
              default: ;
            endcase
          end
        end
        tspf_pkg::ST_ERR: begin
          for (int c = 0; c < 3; c++) begin
            err[c] <= tspf_pkg::sat32(64'(pos[c]) - 64'(target[c]));
          end
          ax      <= '0;
          clamped <= 1'b0;
          sq      <= '0;
        end
        tspf_pkg::ST_INT_ADD: begin
          integ[ax] <= tspf_pkg::sat32(64'(integ[ax]) + (p >>> 16));
          ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
        end
        tspf_pkg::ST_ND: acc <= p >>> FRAC_BITS;
        tspf_pkg::ST_NI: acc <= nsum;
        tspf_pkg::ST_NU: begin
          u[ax] <= tspf_pkg::sat32(-nsum);
          if (ax == 2'd2) begin
            ax  <= '0;
            row <= '0;
            mi  <= '0;
            acc <= '0;
          end else begin
            ax <= ax + 2'd1;
          end
        end
        tspf_pkg::ST_VI: acc <= p;
        tspf_pkg::ST_VSUM: begin
          neg  <= num[63];
          dq   <= tspf_pkg::abs64(num);
          drem <= '0;
          ddiv <= {1'b0, kd_div};
          cnt  <= '0;
        end
        tspf_pkg::ST_DIV: begin
          drem <= div_ge ? 32'(rem_sh - {1'b0, ddiv}) : rem_sh[31:0];
          dq   <= {dq[62:0], div_ge};
          cnt  <= cnt + 6'd1;
        end
        tspf_pkg::ST_VQ: begin
          if (!neg) vc[ax] <= (|dq[63:31]) ? 32'sh80000000 : -$signed(dq[31:0]);
          else vc[ax] <= (|dq[63:31]) ? 32'sh7fffffff : $signed(dq[31:0]);
          ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
        end
        tspf_pkg::ST_SQA: begin
          if (ax == 2'd2) begin
            sx   <= sq + p;
            srem <= '0;
            root <= '0;
            cnt  <= '0;
            ax   <= '0;
          end else begin
            sq <= sq + p;
            ax <= ax + 2'd1;
          end
        end
        tspf_pkg::ST_SQRT: begin
          srem <= sq_ge ? 33'(sq_sh - sq_trial) : sq_sh[32:0];
          root <= {root[30:0], sq_ge};
          sx   <= {sx[61:0], 2'b00};
          cnt  <= cnt + 6'd1;
        end
        tspf_pkg::ST_CMP: begin
          if (root > {1'b0, speed_limit}) clamped <= 1'b1;
          ax <= '0;
        end
        tspf_pkg::ST_CS: begin
          neg  <= p[63];
          dq   <= tspf_pkg::abs64(p);
          drem <= '0;
          ddiv <= root;
          cnt  <= '0;
        end
        tspf_pkg::ST_CQ: begin
          vc[ax] <= neg ? -$signed(dq[31:0]) : $signed(dq[31:0]);
          ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
        end
        tspf_pkg::ST_UA: begin
          u[ax] <= tspf_pkg::sat32(-(p >>> FRAC_BITS));
          if (ax == 2'd2) begin
            ax  <= '0;
            row <= '0;
            mi  <= '0;
            acc <= '0;
          end else begin
            ax <= ax + 2'd1;
          end
        end
        tspf_pkg::ST_FA: begin
          mi <= mi + 4'd1;
          if (ax == 2'd2) begin
            force_v[row] <= tspf_pkg::sat32(nsum);
            acc <= '0;
            row <= row + 2'd1;
            ax  <= '0;
          end else begin
            acc <= nsum;
            ax  <= ax + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== test/task_space_pid_force_tb.sv =====
// Testbench for the task-space PID force regulator (task_space_pid_force).
// Drives random and directed control items, predicts each force vector in-bench and compares.
// Depends on tspf_pkg and the task_space_pid_force RTL.
`timescale 1ns / 1ps
module task_space_pid_force_tb;

  localparam int FB = 16;

  typedef struct {
    logic signed [31:0] fx, fy, fz;
    logic               clamped;
  } force_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [335:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic m_tuser;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task_space_pid_force i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state.
  longint tgt[3];
  longint kp, kd, ki, vlim;
  bit lim_en;
  longint inertia[9];
  int load_ptr;
  longint integ[3];

  force_t expected_forces[$];
  int errors = 0;
  bit no_idle = 0;
  int hold_off = 0;

  function automatic longint sat(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint fshift(longint x);
    return x >>> FB;
  endfunction

  function automatic longint root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  task automatic predict_item(input logic [1:0] op, input logic [335:0] d);
    longint e[3], v[3], vd[3], u[3], vc[3];
    longint dt, kdd, s, n;
    longint unsigned sq;
    force_t f;
    bit clamp;
    clamp = 0;
    if (op == tspf_pkg::OP_LOAD) begin
      inertia[load_ptr] = longint'(signed'(d[31:0]));
      load_ptr = (load_ptr == 8) ? 0 : load_ptr + 1;
      return;
    end
    if (op == tspf_pkg::OP_CLEAR) begin
      for (int c = 0; c < 3; c++) integ[c] = 0;
      return;
    end
    if (op != tspf_pkg::OP_STEP) return;
    dt = longint'(d[335:320]);
    for (int c = 0; c < 3; c++) begin
      e[c] = sat(longint'(signed'(d[32+32*c +: 32])) - tgt[c]);
      v[c] = longint'(signed'(d[128+32*c +: 32]));
      vd[c] = longint'(signed'(d[224+32*c +: 32]));
      integ[c] = sat(integ[c] + ((e[c] * dt) >>> 16));
    end
    if (lim_en) begin
      kdd = (kd != 0) ? kd : 1;
      sq = 0;
      for (int c = 0; c < 3; c++) begin
        vc[c] = sat(-((kp * e[c] + ki * integ[c]) / kdd));
        sq += longint'(vc[c] * vc[c]);
      end
      n = root64(sq);
      if (n > vlim) begin
        clamp = 1;
        for (int c = 0; c < 3; c++) vc[c] = (vc[c] * vlim) / n;
      end
      for (int c = 0; c < 3; c++) u[c] = sat(-fshift(kd * sat(v[c] - vc[c])));
    end else begin
      for (int c = 0; c < 3; c++) begin
        s = fshift(kp * e[c]) + fshift(kd * sat(v[c] - vd[c])) + fshift(ki * integ[c]);
        u[c] = sat(-s);
      end
    end
    f.clamped = clamp;
    for (int r = 0; r < 3; r++) begin
      s = 0;
      for (int c = 0; c < 3; c++) s += fshift(inertia[r*3+c] * u[c]);
      if (r == 0) f.fx = 32'(sat(s));
      else if (r == 1) f.fy = 32'(sat(s));
      else f.fz = 32'(sat(s));
    end
    expected_forces.push_back(f);
  endtask

  // Result checker and receiver stall.
  always @(posedge clk) begin
    force_t f;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_forces.size() == 0) begin
        $error("unexpected result %h", m_tdata);
        errors++;
      end else begin
        f = expected_forces.pop_front();
        if (m_tdata[31:0] !== f.fx) begin
          $error("force_x expected %0d actual %0d", f.fx, $signed(m_tdata[31:0]));
          errors++;
        end
        if (m_tdata[63:32] !== f.fy) begin
          $error("force_y expected %0d actual %0d", f.fy, $signed(m_tdata[63:32]));
          errors++;
        end
        if (m_tdata[95:64] !== f.fz) begin
          $error("force_z expected %0d actual %0d", f.fz, $signed(m_tdata[95:64]));
          errors++;
        end
        if (m_tuser !== f.clamped) begin
          $error("speed_clamped expected %0b actual %0b", f.clamped, m_tuser);
          errors++;
        end
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 9);
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [335:0] d);
    if (!no_idle) begin
      while ($urandom_range(99) < 9) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= d;
    @(posedge clk iff s_tready);
    predict_item(op, d);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tspf_pkg::CFG_TGT_X: tgt[0] = longint'(signed'(val));
      tspf_pkg::CFG_TGT_Y: tgt[1] = longint'(signed'(val));
      tspf_pkg::CFG_TGT_Z: tgt[2] = longint'(signed'(val));
      tspf_pkg::CFG_GAIN_P: kp = longint'(val[30:0]);
      tspf_pkg::CFG_GAIN_D: kd = longint'(val[30:0]);
      tspf_pkg::CFG_GAIN_I: ki = longint'(val[30:0]);
      tspf_pkg::CFG_LIMIT: vlim = longint'(val[30:0]);
      tspf_pkg::CFG_LIM_EN: lim_en = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // The block may still be busy on a step whose result is held; wait it out.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(8 << FB)) - (4 << FB));
      default: return 32'($signed($urandom_range(512)) - 256);
    endcase
  endfunction

  function automatic logic [335:0] rand_step(input int mode);
    logic [335:0] d;
    d = '0;
    for (int i = 0; i < 10; i++) d[32*i +: 32] = rand_q(mode);
    d[335:320] = $urandom_range(65535);
    return d;
  endfunction

  task automatic load_matrix(input int mode);
    logic [335:0] d;
    for (int i = 0; i < 9; i++) begin
      d = rand_step(2);
      d[31:0] = (mode == 0) ? $urandom : 32'($signed($urandom_range(4 << FB)) - (2 << FB));
      send_item(tspf_pkg::OP_LOAD, d);
    end
  endtask

  task automatic test_directed;
    logic [335:0] d;
    load_matrix(1);
    for (int i = 0; i < 4; i++) begin
      d = (i[0]) ? {16'hffff, {320{1'b1}}} : '0;
      if (i == 2) d = {16'h0, {10{32'h80000000}}};
      if (i == 3) d = {16'h8000, {10{32'h7fffffff}}};
      send_item(tspf_pkg::OP_STEP, d);
    end
    send_item(tspf_pkg::OP_CLEAR, rand_step(0));
    send_item(2'd3, rand_step(0));
    send_item(tspf_pkg::OP_STEP, rand_step(1));
    drain();
  endtask

  task automatic test_law(input bit en, input int rounds);
    int m;
    write_reg(tspf_pkg::CFG_LIM_EN, {31'd0, en});
    for (int k = 0; k < rounds; k++) begin
      m = $urandom_range(2);
      case ($urandom_range(9))
        0: load_matrix($urandom_range(1));
        1: send_item(tspf_pkg::OP_CLEAR, rand_step(0));
        2: send_item(2'd3, rand_step(0));
        default: send_item(tspf_pkg::OP_STEP, rand_step(m));
      endcase
    end
    drain();
  endtask

  task automatic set_gains(input logic [31:0] p, input logic [31:0] dd,
                           input logic [31:0] i, input logic [31:0] l);
    write_reg(tspf_pkg::CFG_GAIN_P, p);
    write_reg(tspf_pkg::CFG_GAIN_D, dd);
    write_reg(tspf_pkg::CFG_GAIN_I, i);
    write_reg(tspf_pkg::CFG_LIMIT, l);
  endtask

  task automatic test_backpressure;
    hold_off = 400;
    for (int k = 0; k < 6; k++) send_item(tspf_pkg::OP_STEP, rand_step(1));
    drain();
  endtask

  initial begin
    tgt = '{0, 0, 0};
    integ = '{0, 0, 0};
    inertia = '{default: 0};
    kp = 50 << FB;
    kd = 14 << FB;
    ki = 0;
    vlim = ((3 << FB) + 5) / 10;
    lim_en = 0;
    load_ptr = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_reg(tspf_pkg::CFG_TGT_X, 32'h80000000);
    write_reg(tspf_pkg::CFG_TGT_Y, 32'h7fffffff);
    write_reg(tspf_pkg::CFG_TGT_Z, 32'h00010000);
    test_law(1'b0, 15);
    test_law(1'b1, 8);
    set_gains(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    test_law(1'b0, 15);
    test_law(1'b1, 8);
    set_gains(32'd0, 32'd0, 32'd0, 32'd0);
    test_law(1'b1, 8);
    test_law(1'b0, 8);
    write_reg(tspf_pkg::CFG_TGT_X, $urandom_range(1 << FB));
    write_reg(tspf_pkg::CFG_TGT_Y, 32'd0);
    write_reg(tspf_pkg::CFG_TGT_Z, 32'hffff0000);
    set_gains(32'd3 << FB, 32'd2 << FB, 32'd1 << FB, 32'd1 << FB);
    test_backpressure();
    test_law(1'b0, 50);
    test_law(1'b1, 25);
    no_idle = 1;
    test_law(1'b0, 20);
    no_idle = 0;
    set_gains($urandom, $urandom | 32'd1, $urandom, $urandom_range(1 << FB));
    test_law(1'b1, 20);
    test_law(1'b0, 20);
    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tspf_pkg.sv
rtl/task_space_pid_force.sv
test/task_space_pid_force_tb.sv
